// ----- rtl/cc20_pkg.sv -----
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared constants, types and helper functions for the ChaCha20 keystream
// XOR block: widths, register indexes, state codes and word operations.
// ----------------------------------------------------------------------------
package cc20_pkg;

  localparam int WORD_W     = 32;
  localparam int COUNT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // The four constant words that open every ChaCha20 input block.
  localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_0_63     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_64_127   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_128_191  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_192_255  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_0_63   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_64_95  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_COUNTER = 3'd6;

  localparam int          DOUBLE_ROUNDS = 10;
  localparam logic [3:0]  LAST_DROUND   = 4'(DOUBLE_ROUNDS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } cc20_state_t;

  typedef logic [3:0][WORD_W-1:0]  cc20_row_t;
  typedef logic [15:0][WORD_W-1:0] cc20_block_t;

  // Rotation of one quarter-round step: 16, 12, 8 and then 7 bits.
  function automatic logic [WORD_W-1:0] step_rotl(input logic [WORD_W-1:0] x,
                                                  input logic [1:0] step);
    logic [WORD_W-1:0] y;
    case (step)
      2'd0:    y = {x[15:0], x[31:16]};
      2'd1:    y = {x[19:0], x[31:20]};
      2'd2:    y = {x[23:0], x[31:24]};
      2'd3:    y = {x[24:0], x[31:25]};
      default: y = x;
    endcase
    return y;
  endfunction

  // Keeps the valid bytes of a word; counts of four and above keep all.
  function automatic logic [WORD_W-1:0] byte_mask(input logic [COUNT_W-1:0] count);
    logic [WORD_W-1:0] m;
    case (count)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  // Rotates the four words of a row towards word 0 by k places.
  function automatic cc20_row_t row_rotl(input cc20_row_t row, input logic [1:0] k);
    cc20_row_t res;
    logic [1:0] src;
    for (int j = 0; j < 4; j++) begin
      src    = 2'(j) + k;
      res[j] = row[src];
    end
    return res;
  endfunction

endpackage

// ----- rtl/cc20_if.sv -----
// ----------------------------------------------------------------------------
// cc20 stream interfaces
// Valid/ready channels for message words into the cipher and for the
// resulting words out of it.
// ----------------------------------------------------------------------------
interface cc20_in_if;
  logic                         valid;
  logic                         ready;
  logic [cc20_pkg::WORD_W-1:0]  data_word;
  logic [cc20_pkg::COUNT_W-1:0] byte_count;
  logic                         last_of_message;

  modport source (output valid, data_word, byte_count, last_of_message, input ready);
  modport sink   (input valid, data_word, byte_count, last_of_message, output ready);
endinterface

interface cc20_out_if;
  logic                         valid;
  logic                         ready;
  logic [cc20_pkg::WORD_W-1:0]  out_word;
  logic [cc20_pkg::COUNT_W-1:0] out_byte_count;
  logic                         out_last;

  modport source (output valid, out_word, out_byte_count, out_last, input ready);
  modport sink   (input valid, out_word, out_byte_count, out_last, output ready);
endinterface

// ----- rtl/chacha20_keystream_xor.sv -----
// ----------------------------------------------------------------------------
// chacha20_keystream_xor
// Timing: a word that opens a 64-byte block is answered after the quarter-round
// steps, the add-back of the input block and the emit state, all on one shared
// add, XOR and rotate unit; no new word is taken meanwhile. Other words are XORed
// with the stored keystream: one word per cycle while the output is taken.
// Reset: synchronous, active low; clears control state, the block counter and
// the registers (initial counter to one). The keystream store is not cleared.
// ----------------------------------------------------------------------------
module chacha20_keystream_xor (
  input  logic                             clk,
  input  logic                             rst_n,
  cc20_in_if.sink                          in_chan,
  cc20_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cc20_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cc20_pkg::*;

  // Configuration registers.
  logic [63:0]       key0_r, key1_r, key2_r, key3_r, nonce0_r;
  logic [WORD_W-1:0] nonce1_r, init_ctr_r;

  // Control state.
  cc20_state_t       state_r, state_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [1:0]        qr_r, qr_nxt;
  logic              diag_r, diag_nxt;
  logic [3:0]        dr_r, dr_nxt;
  logic [3:0]        pos_r, pos_nxt;
  logic              started_r, started_nxt;
  logic [WORD_W-1:0] ctr_r, ctr_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload state.
  cc20_block_t        blk_r, blk_nxt;
  logic [WORD_W-1:0]  use_ctr_r, use_ctr_nxt;
  logic [WORD_W-1:0]  hold_word_r, hold_word_nxt;
  logic [COUNT_W-1:0] hold_count_r, hold_count_nxt;
  logic               hold_last_r, hold_last_nxt;
  logic [WORD_W-1:0]  out_word_r, out_word_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_last_r, out_last_nxt;

  // Datapath nets.
  logic               in_ready, in_fire;
  logic [3:0]         pos_eff;
  logic [WORD_W-1:0]  ctr_eff;
  cc20_block_t        init_vec;
  logic [WORD_W-1:0]  add_x, add_y, add_sum, mix_z, mixed;
  cc20_block_t        col_blk, round_blk;
  logic [3:0][1:0]    rot_k;
  logic [3:0]         fin_idx;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r     <= '0;
      key1_r     <= '0;
      key2_r     <= '0;
      key3_r     <= '0;
      nonce0_r   <= '0;
      nonce1_r   <= '0;
      init_ctr_r <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_0_63:     key0_r     <= cfg_wdata;
        CFG_KEY_64_127:   key1_r     <= cfg_wdata;
        CFG_KEY_128_191:  key2_r     <= cfg_wdata;
        CFG_KEY_192_255:  key3_r     <= cfg_wdata;
        CFG_NONCE_0_63:   nonce0_r   <= cfg_wdata;
        CFG_NONCE_64_95:  nonce1_r   <= cfg_wdata[WORD_W-1:0];
        CFG_INIT_COUNTER: init_ctr_r <= cfg_wdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and the position and counter seen by an incoming word.
  assign in_ready      = (state_r == ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_fire       = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;
  assign pos_eff       = started_r ? pos_r : 4'd0;
  assign ctr_eff       = started_r ? ctr_r : init_ctr_r;
  assign fin_idx       = {qr_r, step_r};

  // Input block of the cipher: constants, key, counter and nonce.
  always_comb begin
    init_vec[0]  = SIGMA_0;
    init_vec[1]  = SIGMA_1;
    init_vec[2]  = SIGMA_2;
    init_vec[3]  = SIGMA_3;
    init_vec[4]  = key0_r[31:0];
    init_vec[5]  = key0_r[63:32];
    init_vec[6]  = key1_r[31:0];
    init_vec[7]  = key1_r[63:32];
    init_vec[8]  = key2_r[31:0];
    init_vec[9]  = key2_r[63:32];
    init_vec[10] = key3_r[31:0];
    init_vec[11] = key3_r[63:32];
    init_vec[12] = (state_r == ST_IDLE) ? ctr_eff : use_ctr_r;
    init_vec[13] = nonce0_r[31:0];
    init_vec[14] = nonce0_r[63:32];
    init_vec[15] = nonce1_r;
  end

  // Shared unit: one add, XOR and rotate. Rounds always work on column 0
  // (words 0, 4, 8, 12); the add-back reuses the adder on word 0.
  always_comb begin
    if (state_r == ST_FINAL) begin
      add_x = blk_r[0];
      add_y = init_vec[fin_idx];
    end else if (!step_r[0]) begin
      add_x = blk_r[0];
      add_y = blk_r[4];
    end else begin
      add_x = blk_r[8];
      add_y = blk_r[12];
    end
    add_sum = add_x + add_y;
    mix_z   = step_r[0] ? blk_r[4] : blk_r[12];
    mixed   = step_rotl(mix_z ^ add_sum, step_r);
  end

  // Write back the column; after the last step of a quarter round the rows
  // shift the next column into place, and after the fourth one they also
  // move to diagonal order or back to column order.
  always_comb begin
    col_blk = blk_r;
    if (!step_r[0]) begin
      col_blk[0]  = add_sum;
      col_blk[12] = mixed;
    end else begin
      col_blk[8]  = add_sum;
      col_blk[4]  = mixed;
    end
    round_blk = col_blk;
    for (int r = 0; r < 4; r++) begin
      if (qr_r != 2'd3) begin
        rot_k[r] = 2'd1;
      end else if (diag_r) begin
        rot_k[r] = 2'(1 - r);
      end else begin
        rot_k[r] = 2'(1 + r);
      end
      if (step_r == 2'd3) begin
        round_blk[4*r +: 4] = row_rotl(col_blk[4*r +: 4], rot_k[r]);
      end
    end
  end

  // Sequencer and output register.
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    qr_nxt         = qr_r;
    diag_nxt       = diag_r;
    dr_nxt         = dr_r;
    pos_nxt        = pos_r;
    started_nxt    = started_r;
    ctr_nxt        = ctr_r;
    blk_nxt        = blk_r;
    use_ctr_nxt    = use_ctr_r;
    hold_word_nxt  = hold_word_r;
    hold_count_nxt = hold_count_r;
    hold_last_nxt  = hold_last_r;
    out_word_nxt   = out_word_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          started_nxt = !in_chan.last_of_message;
          pos_nxt     = in_chan.last_of_message ? 4'd0 : pos_eff + 4'd1;
          ctr_nxt     = ctr_eff;
          if (pos_eff == 4'd0) begin
            // First word of a block: compute a fresh keystream block.
            ctr_nxt        = ctr_eff + 32'd1;
            use_ctr_nxt    = ctr_eff;
            blk_nxt        = init_vec;
            hold_word_nxt  = in_chan.data_word;
            hold_count_nxt = in_chan.byte_count;
            hold_last_nxt  = in_chan.last_of_message;
            step_nxt       = 2'd0;
            qr_nxt         = 2'd0;
            diag_nxt       = 1'b0;
            dr_nxt         = 4'd0;
            state_nxt      = ST_ROUND;
          end else begin
            out_word_nxt  = (in_chan.data_word ^ blk_r[pos_eff]) &
                            byte_mask(in_chan.byte_count);
            out_count_nxt = in_chan.byte_count;
            out_last_nxt  = in_chan.last_of_message;
            out_valid_nxt = 1'b1;
          end
        end
      end

      ST_ROUND: begin
        blk_nxt  = round_blk;
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          qr_nxt = qr_r + 2'd1;
          if (qr_r == 2'd3) begin
            diag_nxt = !diag_r;
            if (diag_r) begin
              dr_nxt = dr_r + 4'd1;
              if (dr_r == LAST_DROUND) begin
                state_nxt = ST_FINAL;
              end
            end
          end
        end
      end

      ST_FINAL: begin
        // Add the input block back, one word a cycle through a shift line.
        blk_nxt[14:0]      = blk_r[15:1];
        blk_nxt[15]        = add_sum;
        {qr_nxt, step_nxt} = fin_idx + 4'd1;
        if (fin_idx == 4'd15) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        out_word_nxt  = (hold_word_r ^ blk_r[0]) & byte_mask(hold_count_r);
        out_count_nxt = hold_count_r;
        out_last_nxt  = hold_last_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      qr_r        <= '0;
      diag_r      <= 1'b0;
      dr_r        <= '0;
      pos_r       <= '0;
      started_r   <= 1'b0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      qr_r        <= qr_nxt;
      diag_r      <= diag_nxt;
      dr_r        <= dr_nxt;
      pos_r       <= pos_nxt;
      started_r   <= started_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    blk_r        <= blk_nxt;
    use_ctr_r    <= use_ctr_nxt;
    hold_word_r  <= hold_word_nxt;
    hold_count_r <= hold_count_nxt;
    hold_last_r  <= hold_last_nxt;
    out_word_r   <= out_word_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.out_word       = out_word_r;
  assign out_chan.out_byte_count = out_count_r;
  assign out_chan.out_last       = out_last_r;

endmodule
